>>> src/sha1md_pkg.sv
// shared types and constants for the sha-1 message digest block
// used by sha1md_ctrl, sha1md_dp and sha1_message_digest; no dependencies
package sha1md_pkg;

    typedef logic [31:0] t_word;

    // round constants, one per group of twenty rounds
    localparam t_word K_R0 = 32'h5a827999;
    localparam t_word K_R1 = 32'h6ed9eba1;
    localparam t_word K_R2 = 32'h8f1bbcdc;
    localparam t_word K_R3 = 32'hca62c1d6;

    // initial chaining value, index 0 is h0
    localparam logic [4:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic put_byte;   // write the input byte at the current position, count it
        logic pad_byte;   // write the 0x80 marker at the current position
        logic put_len;    // write the bit length into words 14 and 15
        logic start;      // load working variables from the chaining value
        logic round;      // run one compression round
        logic add;        // fold working variables into the chaining value, clear block
        logic next_word;  // step to the next digest word
        logic finish;     // back to the initial chaining value and zero count
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic block_full;  // next byte fills the block
        logic pad_spill;   // marker lands where the length goes
        logic round_last;  // current round is the last one
        logic word_last;   // current digest word is h4
    } t_status;

endpackage

>>> src/sha1md_ctrl.sv
// controller state machine for the sha-1 message digest block
// drives sha1md_dp through sha1md_pkg::t_cmd and reads sha1md_pkg::t_status
module sha1md_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_byte_valid,
    input  logic                i_last_byte,
    input  logic                i_ready,
    input  sha1md_pkg::t_status i_status,
    output sha1md_pkg::t_cmd    o_cmd,
    output logic                o_ready,
    output logic                o_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RND  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // what follows the running compression
    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_PAD1  = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_last  <= n_last;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.put_byte = i_byte_valid;
                    if (i_byte_valid && i_status.block_full) begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_DATA;
                        n_last      = i_last_byte;
                        n_state     = S_RND;
                    end else if (i_last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                case (r_phase)
                    PH_DATA:  n_state = r_last ? S_PAD : S_IDLE;
                    PH_PAD1:  n_state = S_LEN;
                    PH_FINAL: n_state = S_OUT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_PAD: begin
                o_cmd.pad_byte = 1'b1;
                if (i_status.pad_spill) begin
                    o_cmd.start = 1'b1;
                    n_phase     = PH_PAD1;
                    n_state     = S_RND;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                o_cmd.start   = 1'b1;
                n_phase       = PH_FINAL;
                n_state       = S_RND;
            end
            S_OUT: begin
                if (i_ready) begin
                    o_cmd.next_word = 1'b1;
                    if (i_status.word_last) begin
                        o_cmd.finish = 1'b1;
                        n_last       = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/sha1md_dp.sv
// datapath of the sha-1 message digest block: block window, round unit,
// chaining value, byte count and digest word select; uses sha1md_pkg
module sha1md_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1md_pkg::t_cmd    i_cmd,
    input  logic [7:0]          i_data_byte,
    output sha1md_pkg::t_status o_status,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_final_word
);

    logic [15:0][31:0] r_w, n_w;
    logic [4:0][31:0]  r_chain;
    logic [63:0]       r_count;
    logic [6:0]        r_rnd;
    logic [2:0]        r_widx;
    sha1md_pkg::t_word r_a, r_b, r_c, r_d, r_e;

    logic [5:0]        w_pos;
    logic [7:0]        w_byte;
    logic [63:0]       w_len;
    sha1md_pkg::t_word w_x, w_new, w_f, w_k, w_t;

    assign w_pos  = r_count[5:0];
    assign w_byte = i_cmd.put_byte ? i_data_byte : sha1md_pkg::PAD_BYTE;
    assign w_len  = {r_count[60:0], 3'b000};

    // window holds w[r..r+15]; the incoming word is w[r+16]
    assign w_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = sha1md_pkg::K_R0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1md_pkg::K_R1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = sha1md_pkg::K_R2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1md_pkg::K_R3;
        end
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];

    always_comb begin
        n_w = r_w;
        if (i_cmd.add) begin
            n_w = '0;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = w_new;
        end else begin
            if (i_cmd.put_byte || i_cmd.pad_byte) begin
                // lane 0 is the most significant byte
                n_w[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] = w_byte;
            end
            if (i_cmd.put_len) begin
                n_w[14] = w_len[63:32];
                n_w[15] = w_len[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else begin
            r_w <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= sha1md_pkg::H_INIT;
            r_count <= '0;
            r_rnd   <= '0;
            r_widx  <= '0;
        end else begin
            if (i_cmd.put_byte) begin
                r_count <= r_count + 64'd1;
            end
            if (i_cmd.start) begin
                r_rnd <= '0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
            end
            if (i_cmd.add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (i_cmd.finish) begin
                r_chain <= sha1md_pkg::H_INIT;
                r_count <= '0;
                r_widx  <= '0;
            end else if (i_cmd.next_word) begin
                r_widx <= r_widx + 3'd1;
            end
        end
    end

    // working variables carry no reset: always loaded before use
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_status.block_full = (w_pos == 6'd63);
    assign o_status.pad_spill  = (w_pos[5:3] == 3'b111);
    assign o_status.round_last = (r_rnd == sha1md_pkg::LAST_ROUND);
    assign o_status.word_last  = (r_widx == sha1md_pkg::LAST_WORD);

    assign o_digest_word = r_chain[r_widx];
    assign o_word_index  = r_widx;
    assign o_final_word  = (r_widx == sha1md_pkg::LAST_WORD);

endmodule

>>> src/sha1_message_digest.sv
// sha-1 digest, one message byte per transfer, digest out as five words h0..h4
// a byte that completes a block is followed by the rounds and an add before more input
// a last item's digest follows compression of padding and length, plus an extra block
// when padding spills or the item completes a block; input waits for all 5 word transfers
// reset (synchronous, active low) sets the initial chaining value and zero count
// built from sha1md_ctrl and sha1md_dp, types from sha1md_pkg
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);

    sha1md_pkg::t_cmd    w_cmd;
    sha1md_pkg::t_status w_status;

    sha1md_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_valid (i_byte_valid),
        .i_last_byte  (i_last_byte),
        .i_ready      (i_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_ready      (o_ready),
        .o_valid      (o_valid)
    );

    sha1md_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .o_status      (w_status),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_final_word  (o_final_word)
    );

    // no input transfer while a digest is being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output channels active together");

    // digest words step up by one per transfer
    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_final_word) |=>
        (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    // after the last digest word the block takes input again
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_final_word) |=> (o_ready && !o_valid))
        else $error("not idle after digest");

endmodule
